// File: rtl/core/pm_pkg.sv
// Shared types and constants of the polynomial multiplier.
package pm_pkg;

  // Input transaction fields
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned TERM_EXP_W   = 5;
  localparam int unsigned TERM_COEF_W  = 32;
  localparam int unsigned S_TDATA_W    = 40;

  // Result transaction fields
  localparam int unsigned PROD_EXP_W   = 6;
  localparam int unsigned PROD_COEF_W  = 32;
  localparam int unsigned M_TDATA_W    = 40;

  // Configuration port
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned DEG_W        = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DEGREE  = 1'b0,
    CFG_SECOND_DEGREE = 1'b1
  } cfg_index_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_MULTIPLY    = 2'd2
  } opcode_e;

endpackage

// File: rtl/core/pm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/polynomial_multiplier.sv
// Polynomial multiplier: coefficient stores, multiply-accumulate walk and result register.
// Load transaction: accepted while idle; the next transaction may follow in the next cycle.
// Multiply transaction: (d1+1)*(d2+1) multiply-accumulates, one per pair, issued in turn
//   through the single read port of each RAM and held while the result register is full;
//   the next transaction is accepted once the last pair has been read from both RAMs.
// Reset: degrees return to 0 and the per-entry valid bits clear, so both stores read as zero
//   at once; no clearing pass. The valid bits clear again after every multiply.
module polynomial_multiplier
  import pm_pkg::*;
#(
  parameter int unsigned MAX_DEGREE  = 31,
  parameter int unsigned COEFF_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Item stream. tdata: opcode [1:0], term_exponent [6:2], term_coefficient [38:7], zero [39]
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  // Result stream. tdata: product_exponent [5:0], product_coefficient [37:6], zero [39:38]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [M_TDATA_W-1:0]   m_axis_tdata,
  output logic                   m_axis_tlast,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DEG_W-1:0]       cfg_data_i
);

  // Only the low bits of each product reach the output, so the stores and the
  // datapath keep at most 32 bits of every coefficient.
  localparam int unsigned AccW  = (COEFF_WIDTH < PROD_COEF_W) ? COEFF_WIDTH : PROD_COEF_W;
  localparam int unsigned Depth = MAX_DEGREE + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned KW    = $clog2(2 * MAX_DEGREE + 1);

  typedef enum logic {
    IDLE,
    RUN
  } state_e;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  opcode_e                 in_op;
  logic [TERM_EXP_W-1:0]   in_exp;
  logic [TERM_COEF_W-1:0]  in_coef;
  logic                    in_fire;

  assign in_op   = opcode_e'(s_axis_tdata[OPCODE_W-1:0]);
  assign in_exp  = s_axis_tdata[OPCODE_W +: TERM_EXP_W];
  assign in_coef = s_axis_tdata[OPCODE_W+TERM_EXP_W +: TERM_COEF_W];

  // --------------------------------------------------------------------------
  // Configuration: degree registers, clamped to the parameter on use
  // --------------------------------------------------------------------------
  logic [DEG_W-1:0] first_degree_q, second_degree_q;
  logic [AddrW-1:0] d1_eff, d2_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_degree_q  <= '0;
      second_degree_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FIRST_DEGREE:  first_degree_q  <= cfg_data_i;
        CFG_SECOND_DEGREE: second_degree_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign d1_eff = (first_degree_q > DEG_W'(MAX_DEGREE)) ? AddrW'(MAX_DEGREE)
                                                        : first_degree_q[AddrW-1:0];
  assign d2_eff = (second_degree_q > DEG_W'(MAX_DEGREE)) ? AddrW'(MAX_DEGREE)
                                                         : second_degree_q[AddrW-1:0];

  // --------------------------------------------------------------------------
  // Sequencer: walks exponent k from d1+d2 down to 0, and for each k the
  // first-polynomial index i over every pair with i+j == k inside both degrees.
  // --------------------------------------------------------------------------
  state_e           state_q;
  logic [KW-1:0]    k_q;
  logic [AddrW-1:0] i_q, d1_q, d2_q;
  logic             first_q;
  logic [Depth-1:0] p_vld_q, q_vld_q;

  logic             adv;        // pipeline moves on this cycle
  logic             issue;      // one multiply-accumulate read pair issued
  logic             last_i;     // final pair of the current exponent
  logic             walk_done;  // final pair of the whole product
  logic [AddrW-1:0] i_hi;
  logic [KW-1:0]    k_dec;
  logic [AddrW-1:0] i_lo_next;
  logic [AddrW-1:0] j_addr;
  logic [KW-1:0]    j_full;
  logic             load_p, load_q;
  logic [AddrW-1:0] load_addr;
  logic [AccW-1:0]  load_data;

  assign s_axis_tready = (state_q == IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // drop loads above the effective degree
  assign load_addr = in_exp[AddrW-1:0];
  assign load_data = in_coef[AccW-1:0];
  assign load_p    = in_fire && (in_op == OP_LOAD_FIRST)
                     && (in_exp <= TERM_EXP_W'(d1_eff));
  assign load_q    = in_fire && (in_op == OP_LOAD_SECOND)
                     && (in_exp <= TERM_EXP_W'(d2_eff));

  assign i_hi      = (k_q < KW'(d1_q)) ? k_q[AddrW-1:0] : d1_q;
  assign last_i    = (i_q == i_hi);
  assign k_dec     = k_q - KW'(1);
  assign i_lo_next = (k_dec > KW'(d2_q)) ? AddrW'(k_dec - KW'(d2_q)) : '0;
  assign j_full    = k_q - KW'(i_q);
  assign j_addr    = j_full[AddrW-1:0];

  assign issue     = (state_q == RUN) && adv;
  assign walk_done = issue && last_i && (k_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      k_q     <= '0;
      i_q     <= '0;
      d1_q    <= '0;
      d2_q    <= '0;
      first_q <= 1'b0;
      p_vld_q <= '0;
      q_vld_q <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (load_p) begin
            p_vld_q[load_addr] <= 1'b1;
          end
          if (load_q) begin
            q_vld_q[load_addr] <= 1'b1;
          end
          if (in_fire && (in_op == OP_MULTIPLY)) begin
            state_q <= RUN;
            d1_q    <= d1_eff;
            d2_q    <= d2_eff;
            k_q     <= KW'(d1_eff) + KW'(d2_eff);
            // the top exponent has a single pair, starting at i = d1
            i_q     <= d1_eff;
            first_q <= 1'b1;
          end
        end
        RUN: begin
          if (issue) begin
            if (walk_done) begin
              // the last reads have captured their valid bits: clear both stores
              state_q <= IDLE;
              p_vld_q <= '0;
              q_vld_q <= '0;
            end else if (last_i) begin
              k_q     <= k_dec;
              i_q     <= i_lo_next;
              first_q <= 1'b1;
            end else begin
              i_q     <= i_q + AddrW'(1);
              first_q <= 1'b0;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Coefficient stores
  // --------------------------------------------------------------------------
  logic [AccW-1:0] p_rdata, q_rdata;

  pm_ram #(
    .WIDTH (AccW),
    .DEPTH (Depth)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (load_p),
    .waddr_i (load_addr),
    .wdata_i (load_data),
    .re_i    (issue),
    .raddr_i (i_q),
    .rdata_o (p_rdata)
  );

  pm_ram #(
    .WIDTH (AccW),
    .DEPTH (Depth)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (load_q),
    .waddr_i (load_addr),
    .wdata_i (load_data),
    .re_i    (issue),
    .raddr_i (j_addr),
    .rdata_o (q_rdata)
  );

  // --------------------------------------------------------------------------
  // Multiply-accumulate pipeline: read -> multiply -> accumulate.
  // The whole pipeline holds while a finished sum waits for a full result register.
  // --------------------------------------------------------------------------
  logic            s1_vld_q, s1_first_q, s1_last_q, s1_pv_q, s1_qv_q;
  logic [KW-1:0]   s1_k_q;
  logic            s2_vld_q, s2_first_q, s2_last_q;
  logic [KW-1:0]   s2_k_q;
  logic [AccW-1:0] s2_prod_q;
  logic [AccW-1:0] acc_q;

  logic [AccW-1:0]   p_op, q_op;
  logic [2*AccW-1:0] prod_full;
  logic [AccW-1:0]   sum;

  logic                   out_valid_q, out_last_q;
  logic [KW-1:0]          out_exp_q;
  logic [AccW-1:0]        out_coef_q;
  logic                   out_load;

  assign adv = !(s2_vld_q && s2_last_q && out_valid_q && !m_axis_tready);

  // entries never written since the last clear read as zero
  assign p_op      = s1_pv_q ? p_rdata : '0;
  assign q_op      = s1_qv_q ? q_rdata : '0;
  assign prod_full = p_op * q_op;
  assign sum       = s2_first_q ? s2_prod_q : acc_q + s2_prod_q;
  assign out_load  = adv && s2_vld_q && s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_first_q <= first_q;
      s1_last_q  <= last_i;
      s1_k_q     <= k_q;
      s1_pv_q    <= p_vld_q[i_q];
      s1_qv_q    <= q_vld_q[j_addr];
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_k_q     <= s1_k_q;
      s2_prod_q  <= prod_full[AccW-1:0];
      if (s2_vld_q) begin
        acc_q <= sum;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_exp_q  <= s2_k_q;
      out_coef_q <= sum;
      out_last_q <= (s2_k_q == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = M_TDATA_W'({PROD_COEF_W'($signed(out_coef_q)),
                                     PROD_EXP_W'(out_exp_q)});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_issue_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (state_q == RUN))
    else $error("coefficient read issued outside a multiply");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RUN) |-> (i_q <= d1_q) && (k_q <= KW'(d1_q) + KW'(d2_q)))
    else $error("walk index beyond the latched degrees");

  a_stores_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |=> (p_vld_q == '0) && (q_vld_q == '0))
    else $error("stores not cleared after a multiply");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_coef_q) && $stable(out_exp_q))
    else $error("pending result overwritten");

endmodule

// File: tb/sv/tb_polynomial_multiplier.sv
// Self-checking testbench of the polynomial multiplier: streamed terms, checked products.
module tb_polynomial_multiplier
  import pm_pkg::*;
;

  // Opcode 3 has no member in opcode_e; the block must ignore it
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STORE_DEPTH = 32;
  // Quiet cycles before a register write or the verdict: covers a load still in flight
  // and the path from acceptance through the pipeline to the first product
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [TERM_EXP_W-1:0]  exponent;
    logic [TERM_COEF_W-1:0] coefficient;
  } term_t;

  typedef struct packed {
    logic [PROD_EXP_W-1:0]  exponent;
    logic [PROD_COEF_W-1:0] coefficient;
    logic                   last;
  } product_t;

  logic                 clk_i = 1'b1;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DEG_W-1:0]     cfg_data_i = '0;

  polynomial_multiplier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Terms waiting to be offered, products waiting to be seen
  term_t    pending_terms[$];
  product_t expected_products[$];

  // Shadow of the block: both coefficient stores and both degree registers
  logic [TERM_COEF_W-1:0] first_store [STORE_DEPTH];
  logic [TERM_COEF_W-1:0] second_store[STORE_DEPTH];
  logic [DEG_W-1:0]       first_deg;
  logic [DEG_W-1:0]       second_deg;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  logic        results_held       = 1'b0;
  logic        term_taken         = 1'b0;
  int unsigned failures           = 0;
  int unsigned cycle_count        = 0;

  initial begin
    for (int n = 0; n < STORE_DEPTH; n++) begin
      first_store[n]  = '0;
      second_store[n] = '0;
    end
    first_deg  = '0;
    second_deg = '0;
  end

  // Apply one accepted term to the shadow stores; a multiply queues every product
  // coefficient from the top exponent down to zero, then empties both stores.
  function automatic void apply_term(input term_t t);
    int                     k;
    int                     i;
    int                     j;
    logic [PROD_COEF_W-1:0] acc;
    product_t               p;
    case (t.opcode)
      OP_LOAD_FIRST: begin
        if (t.exponent <= first_deg) first_store[t.exponent] = t.coefficient;
      end
      OP_LOAD_SECOND: begin
        if (t.exponent <= second_deg) second_store[t.exponent] = t.coefficient;
      end
      OP_MULTIPLY: begin
        for (k = int'(first_deg) + int'(second_deg); k >= 0; k--) begin
          acc = '0;
          for (i = 0; i <= int'(first_deg); i++) begin
            j = k - i;
            // 32-bit context keeps the low half of each product, i.e. the wrapped sum
            if (j >= 0 && j <= int'(second_deg)) acc = acc + first_store[i] * second_store[j];
          end
          p.exponent    = k[PROD_EXP_W-1:0];
          p.coefficient = acc;
          p.last        = (k == 0);
          expected_products.push_back(p);
        end
        for (i = 0; i < STORE_DEPTH; i++) begin
          first_store[i]  = '0;
          second_store[i] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Monitor: check each product transaction, then track accepted terms and register writes
  always @(posedge clk_i) begin
    product_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    term_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_products.size() == 0) begin
        $error("unexpected product: exponent %0d, coefficient %0h",
               m_axis_tdata[PROD_EXP_W-1:0], m_axis_tdata[PROD_EXP_W +: PROD_COEF_W]);
        failures++;
      end else begin
        want = expected_products.pop_front();
        if (m_axis_tdata[PROD_EXP_W-1:0] !== want.exponent) begin
          $error("product_exponent: expected %0d, got %0d",
                 want.exponent, m_axis_tdata[PROD_EXP_W-1:0]);
          failures++;
        end
        if (m_axis_tdata[PROD_EXP_W +: PROD_COEF_W] !== want.coefficient) begin
          $error("product_coefficient: expected %0h, got %0h",
                 want.coefficient, m_axis_tdata[PROD_EXP_W +: PROD_COEF_W]);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_term: expected %0b, got %0b", want.last, m_axis_tlast);
          failures++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      apply_term(term_t'({s_axis_tdata[OPCODE_W-1:0],
                          s_axis_tdata[OPCODE_W +: TERM_EXP_W],
                          s_axis_tdata[OPCODE_W+TERM_EXP_W +: TERM_COEF_W]}));
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FIRST_DEGREE:  first_deg  = cfg_data_i;
        CFG_SECOND_DEGREE: second_deg = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Driver: hold a term until its transaction completes, then offer the next or go idle
  always @(negedge clk_i) begin
    term_t t;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || term_taken) begin
      if (pending_terms.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        t = pending_terms.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, t.coefficient, t.exponent, t.opcode};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while results_held is set
  always @(negedge clk_i) begin
    m_axis_tready <= !results_held && ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic add_term(input logic [OPCODE_W-1:0] op, input int unsigned e,
                          input logic [TERM_COEF_W-1:0] c);
    term_t t;
    t.opcode      = op;
    t.exponent    = e[TERM_EXP_W-1:0];
    t.coefficient = c;
    pending_terms.push_back(t);
  endtask

  function automatic logic [TERM_COEF_W-1:0] random_coefficient();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Wait until every term is taken and every product seen, then let the block settle
  task automatic settle();
    while (pending_terms.size() != 0 || s_axis_tvalid || expected_products.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_degree(input cfg_index_e idx, input logic [DEG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One phase: set the degrees while idle, choose the idling mix, then queue load/multiply
  // sequences with random content and a sprinkling of noise until the budget is spent.
  task automatic run_phase(input int unsigned d1, input int unsigned d2,
                           input int unsigned sender_pct, input int unsigned receiver_pct,
                           input int unsigned budget, input int unsigned hold_cycles);
    int unsigned count;
    int unsigned n;
    settle();
    write_degree(CFG_FIRST_DEGREE, d1[DEG_W-1:0]);
    write_degree(CFG_SECOND_DEGREE, d2[DEG_W-1:0]);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    if (hold_cycles != 0) begin
      // Block the result side for a long stretch so the block backs up onto its input
      fork
        begin
          @(posedge clk_i);
          results_held = 1'b1;
          repeat (hold_cycles) @(posedge clk_i);
          results_held = 1'b0;
        end
      join_none
    end
    count = 0;
    while (count < budget) begin
      // Cap the loads per polynomial so large degrees still see several multiplies
      n = $urandom_range(1, (d1 < 9) ? d1 + 1 : 10);
      repeat (n) add_term(OP_LOAD_FIRST,
                          ($urandom_range(99) < 85) ? $urandom_range(d1) : $urandom_range(31),
                          random_coefficient());
      count += n;
      n = $urandom_range(1, (d2 < 9) ? d2 + 1 : 10);
      repeat (n) add_term(OP_LOAD_SECOND,
                          ($urandom_range(99) < 85) ? $urandom_range(d2) : $urandom_range(31),
                          random_coefficient());
      count += n;
      if ($urandom_range(99) < 20) begin
        add_term(OPCODE_W'($urandom_range(3)), $urandom_range(31), $urandom);
        count++;
      end
      if ($urandom_range(99) < 10) begin
        add_term(OP_UNUSED, $urandom_range(31), $urandom);
        count++;
      end
      add_term(OP_MULTIPLY, $urandom_range(31), $urandom);
      count++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Degrees at reset are both zero: a single product, wrapped square of the maximum
    add_term(OP_LOAD_FIRST, 0, 32'h7FFF_FFFF);
    add_term(OP_LOAD_SECOND, 0, 32'h7FFF_FFFF);
    add_term(OP_LOAD_FIRST, 1, 32'h0000_0005);   // above the degree, dropped
    add_term(OP_UNUSED, 0, 32'h0000_007B);       // ignored, no state change
    add_term(OP_MULTIPLY, 31, 32'hFFFF_FFFF);    // multiply ignores its other fields
    add_term(OP_MULTIPLY, 0, 32'h0000_0000);     // stores cleared: zero product
    settle();

    // Both degrees at the maximum: full 63-term product with extreme coefficients
    write_degree(CFG_FIRST_DEGREE, 5'd31);
    write_degree(CFG_SECOND_DEGREE, 5'd31);
    add_term(OP_LOAD_FIRST, 31, 32'h8000_0000);
    add_term(OP_LOAD_FIRST, 0, 32'h7FFF_FFFF);
    add_term(OP_LOAD_FIRST, 17, 32'hFFFF_FFFF);
    add_term(OP_LOAD_SECOND, 31, 32'h8000_0000);
    add_term(OP_LOAD_SECOND, 0, 32'hFFFF_FFFF);
    add_term(OP_LOAD_SECOND, 5, 32'h0000_0001);
    add_term(OP_MULTIPLY, 0, 32'h0000_0000);
    add_term(OP_UNUSED, 31, 32'hFFFF_FFFF);
    add_term(OP_MULTIPLY, 12, 32'h1234_5678);

    run_phase(3, 2, 0, 0, 60, 0);
    run_phase(31, 31, 59, 0, 60, 0);
    run_phase(0, 31, 0, 59, 60, 0);
    run_phase(31, 0, 35, 35, 60, 0);
    run_phase($urandom_range(7), $urandom_range(7), 0, 0, 60, 400);
    run_phase(5, 7, 35, 35, 60, 0);
    settle();

    if (expected_products.size() != 0) begin
      $error("%0d products never arrived", expected_products.size());
      failures++;
    end
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pm_pkg.sv
rtl/core/pm_ram.sv
rtl/core/polynomial_multiplier.sv
tb/sv/tb_polynomial_multiplier.sv
